// ===== design/assert_macros.svh =====
// assertion macros used by the ordered list controller rtl
// expects clk_i and rst_ni in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, sampled on the rising clock, off during reset
`define OAL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication form, same cycle
`define OAL_ASSERT_IMPL(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// implication form, following cycle
`define OAL_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== design/oal_pkg.sv =====
// types, codes and defaults for the ordered list engine
// no dependencies
`default_nettype none

package oal_pkg;

  localparam int unsigned CNT_W          = 7;
  localparam int unsigned CNT_MAX        = (2 ** CNT_W) - 1;
  localparam int unsigned VAL_W          = 32;
  localparam int unsigned DEF_CAPACITY   = 64;
  localparam int unsigned DEF_DATA_WIDTH = 32;
  localparam logic [CNT_W-1:0] MAX_ENTRIES_RST = 7'd64;

  typedef enum logic [1:0] {
    K_INSERT   = 2'd0,
    K_REMOVE   = 2'd1,
    K_GET      = 2'd2,
    K_CONTAINS = 2'd3
  } oal_kind_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } oal_status_e;

  typedef struct packed {
    oal_kind_e        kind;
    logic [CNT_W-1:0] position;
    logic             at_end;
    logic [VAL_W-1:0] value;
  } oal_in_t;

  typedef struct packed {
    oal_status_e      status;
    logic [VAL_W-1:0] read_value;
    logic             found;
    logic [CNT_W-1:0] item_count;
  } oal_out_t;

  typedef struct packed {
    logic idle;
    logic done;
  } oal_stat_t;

endpackage

`default_nettype wire

// ===== design/oal_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module oal_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== design/oal_ctrl.sv =====
// sequencer for the ordered list: checks, shifts, reads and scans the entry ram
// depends on oal_pkg, oal_ram and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module oal_ctrl import oal_pkg::*; #(
  parameter int unsigned CAPACITY   = DEF_CAPACITY,
  parameter int unsigned DATA_WIDTH = DEF_DATA_WIDTH
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire oal_in_t          req_i,
  input  wire logic [CNT_W-1:0] limit_i,
  input  wire logic             take_i,
  output oal_stat_t             stat_o,
  output oal_out_t              res_o
);

  localparam int unsigned ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned WIDE_W = (ADDR_W > CNT_W) ? ADDR_W : CNT_W;

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_UP        = 4'd1;
  localparam logic [3:0] S_UP_LAST   = 4'd2;
  localparam logic [3:0] S_PUT       = 4'd3;
  localparam logic [3:0] S_DOWN      = 4'd4;
  localparam logic [3:0] S_DOWN_LAST = 4'd5;
  localparam logic [3:0] S_GET       = 4'd6;
  localparam logic [3:0] S_SCAN      = 4'd7;
  localparam logic [3:0] S_SCAN_LAST = 4'd8;
  localparam logic [3:0] S_DONE      = 4'd9;

  function automatic logic [ADDR_W-1:0] to_addr(input logic [CNT_W-1:0] idx);
    logic [WIDE_W-1:0] wide;
    wide = WIDE_W'(idx);
    return wide[ADDR_W-1:0];
  endfunction

  logic [3:0]            state_q, state_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic                  rvalid_q, rvalid_d;
  logic [CNT_W-1:0]      ptr_q, ptr_d;
  logic [CNT_W-1:0]      end_q, end_d;
  logic [CNT_W-1:0]      wptr_q, wptr_d;
  oal_kind_e             kind_q, kind_d;
  logic [DATA_WIDTH-1:0] val_q, val_d;
  oal_status_e           status_q, status_d;
  logic [DATA_WIDTH-1:0] rdata_q, rdata_d;
  logic                  found_q, found_d;

  logic                  mem_re, mem_we;
  logic [CNT_W-1:0]      mem_ridx, mem_widx;
  logic [DATA_WIDTH-1:0] mem_wdata, mem_rdata;
  logic [CNT_W-1:0]      idx_ins, idx_rg;
  logic                  shift_op;

  assign idx_ins  = req_i.at_end ? count_q : req_i.position;
  assign idx_rg   = req_i.at_end ? (count_q - 7'd1) : req_i.position;
  assign shift_op = (kind_q == K_INSERT) || (kind_q == K_REMOVE);

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    rvalid_d  = 1'b0;
    ptr_d     = ptr_q;
    end_d     = end_q;
    wptr_d    = wptr_q;
    kind_d    = kind_q;
    val_d     = val_q;
    status_d  = status_q;
    rdata_d   = rdata_q;
    found_d   = found_q;
    mem_re    = 1'b0;
    mem_ridx  = ptr_q;
    mem_we    = rvalid_q && shift_op;
    mem_widx  = wptr_q;
    mem_wdata = mem_rdata;

    // compare the word read in the previous cycle
    if (rvalid_q && (kind_q == K_CONTAINS) && (mem_rdata == val_q)) begin
      found_d = 1'b1;
    end

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          kind_d   = req_i.kind;
          val_d    = DATA_WIDTH'(req_i.value);
          status_d = ST_OK;
          rdata_d  = '0;
          found_d  = 1'b0;
          case (req_i.kind)
            K_INSERT: begin
              if (idx_ins > count_q) begin
                status_d = ST_RANGE;
                state_d  = S_DONE;
              end else if (count_q >= limit_i) begin
                status_d = ST_FULL;
                state_d  = S_DONE;
              end else begin
                count_d = count_q + 7'd1;
                end_d   = idx_ins;
                if (idx_ins == count_q) begin
                  state_d = S_PUT;
                end else begin
                  ptr_d   = count_q - 7'd1;
                  state_d = S_UP;
                end
              end
            end
            K_REMOVE, K_GET: begin
              if (count_q == '0) begin
                status_d = ST_EMPTY;
                state_d  = S_DONE;
              end else if (idx_rg >= count_q) begin
                status_d = ST_RANGE;
                state_d  = S_DONE;
              end else if (req_i.kind == K_GET) begin
                mem_re   = 1'b1;
                mem_ridx = idx_rg;
                rvalid_d = 1'b1;
                state_d  = S_GET;
              end else begin
                count_d = count_q - 7'd1;
                if (idx_rg == (count_q - 7'd1)) begin
                  state_d = S_DONE;
                end else begin
                  ptr_d   = idx_rg + 7'd1;
                  end_d   = count_q - 7'd1;
                  state_d = S_DOWN;
                end
              end
            end
            K_CONTAINS: begin
              if (count_q == '0) begin
                state_d = S_DONE;
              end else begin
                ptr_d   = '0;
                end_d   = count_q - 7'd1;
                state_d = S_SCAN;
              end
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_UP: begin
        mem_re   = 1'b1;
        rvalid_d = 1'b1;
        wptr_d   = ptr_q + 7'd1;
        if (ptr_q == end_q) begin
          state_d = S_UP_LAST;
        end else begin
          ptr_d = ptr_q - 7'd1;
        end
      end
      S_UP_LAST: begin
        state_d = S_PUT;
      end
      S_PUT: begin
        mem_we    = 1'b1;
        mem_widx  = end_q;
        mem_wdata = val_q;
        state_d   = S_DONE;
      end
      S_DOWN: begin
        mem_re   = 1'b1;
        rvalid_d = 1'b1;
        wptr_d   = ptr_q - 7'd1;
        if (ptr_q == end_q) begin
          state_d = S_DOWN_LAST;
        end else begin
          ptr_d = ptr_q + 7'd1;
        end
      end
      S_DOWN_LAST: begin
        state_d = S_DONE;
      end
      S_GET: begin
        rdata_d = mem_rdata;
        state_d = S_DONE;
      end
      S_SCAN: begin
        mem_re   = 1'b1;
        rvalid_d = 1'b1;
        if (ptr_q == end_q) begin
          state_d = S_SCAN_LAST;
        end else begin
          ptr_d = ptr_q + 7'd1;
        end
      end
      S_SCAN_LAST: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (take_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      rvalid_q <= rvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q    <= ptr_d;
    end_q    <= end_d;
    wptr_q   <= wptr_d;
    kind_q   <= kind_d;
    val_q    <= val_d;
    status_q <= status_d;
    rdata_q  <= rdata_d;
    found_q  <= found_d;
  end

  oal_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (to_addr(mem_widx)),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (to_addr(mem_ridx)),
    .rdata_o (mem_rdata)
  );

  assign stat_o.idle = (state_q == S_IDLE);
  assign stat_o.done = (state_q == S_DONE);

  assign res_o.status     = status_q;
  assign res_o.read_value = VAL_W'(rdata_q);
  assign res_o.found      = found_q;
  assign res_o.item_count = count_q;

  `OAL_ASSERT_IMPL(a_no_rw_clash, mem_we && mem_re, mem_widx != mem_ridx, "ram read and write collide")
  `OAL_ASSERT_IMPL(a_start_idle, start_i, state_q == S_IDLE, "request started while busy")
  `OAL_ASSERT_NEXT(a_count_hold, state_q != S_IDLE, $stable(count_q), "count moved mid operation")

endmodule

`default_nettype wire

// ===== design/ordered_array_list_engine.sv =====
// Ordered list engine: an ordered list of up to max_entries words held in one
// single-port-read, single-port-write ram, plus a live count. One request at a time
// is processed and gives one result. Get reads one entry. Insert moves each entry
// from the insert position up one place, then writes the new word; an append only
// writes. Remove moves each later entry down one place. Contains reads every entry.
// An error, a remove of the last entry or a contains on an empty list touches no
// ram word. The entry ram is read and written once a cycle while entries move. A new
// request is taken while the last result still waits in the output register. No
// clearing pass after reset.
`default_nettype none

module ordered_array_list_engine import oal_pkg::*; #(
  parameter int unsigned CAPACITY   = DEF_CAPACITY,
  parameter int unsigned DATA_WIDTH = DEF_DATA_WIDTH
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire oal_in_t          in_req_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output oal_out_t              out_res_o,
  input  wire logic             cfg_we_i,
  input  wire logic [CNT_W-1:0] cfg_wdata_i
);

  localparam logic [CNT_W-1:0] CAP_CLIP =
    (CAPACITY > CNT_MAX) ? CNT_W'(CNT_MAX) : CNT_W'(CAPACITY);

  logic [CNT_W-1:0] max_entries_q;
  logic [CNT_W-1:0] limit_raw, limit;
  logic             out_valid_q, out_valid_d;
  oal_out_t         out_res_q;
  oal_out_t         res;
  oal_stat_t        stat;
  logic             start, take;

  // a limit of zero acts as one, anything above capacity, or above 127, as the lower of the two
  assign limit_raw = (max_entries_q == '0) ? 7'd1 : max_entries_q;
  assign limit     = (limit_raw > CAP_CLIP) ? CAP_CLIP : limit_raw;

  assign in_stall_o = !stat.idle;
  assign start      = in_valid_i && stat.idle;
  assign take       = stat.done && (!out_valid_q || !out_stall_i);

  always_comb begin
    out_valid_d = out_valid_q;
    if (take) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_entries_q <= MAX_ENTRIES_RST;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        max_entries_q <= cfg_wdata_i;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_res_q <= res;
    end
  end

  oal_ctrl #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .req_i   (in_req_i),
    .limit_i (limit),
    .take_i  (take),
    .stat_o  (stat),
    .res_o   (res)
  );

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

endmodule

`default_nettype wire
